// ===== design/lbpe_pkg.sv =====
// Package with shared types and constants for the link bandwidth probe engine.
`default_nettype none
package lbpe_pkg;
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_START  = 3'd1;
    localparam logic [2:0] FUNC_BEGIN  = 3'd2;
    localparam logic [2:0] FUNC_ACK    = 3'd3;
    localparam logic [2:0] FUNC_DATA   = 3'd4;
    localparam logic [2:0] FUNC_REPORT = 3'd5;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_BEGIN  = 3'd1;
    localparam logic [2:0] KIND_ACK    = 3'd2;
    localparam logic [2:0] KIND_DATA   = 3'd3;
    localparam logic [2:0] KIND_REPORT = 3'd4;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_WACK    = 3'd1;
    localparam logic [2:0] MODE_SEND    = 3'd2;
    localparam logic [2:0] MODE_WREP    = 3'd3;
    localparam logic [2:0] MODE_COUNT   = 3'd4;
    localparam logic [2:0] MODE_DONE_TX = 3'd5;
    localparam logic [2:0] MODE_DONE_RX = 3'd6;
    localparam logic [2:0] MODE_HOLD    = 3'd7;

    localparam logic [2:0] REG_PACKETS  = 3'd0;
    localparam logic [2:0] REG_BYTES    = 3'd1;
    localparam logic [2:0] REG_INTERVAL = 3'd2;
    localparam logic [2:0] REG_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_IDLE     = 3'd4;
    localparam logic [2:0] REG_HOLDOFF  = 3'd5;

    localparam logic [15:0] DEFAULT_PACKETS = 16'd200;
    localparam logic [15:0] DEFAULT_BYTES   = 16'd8192;

    // Input request payload.
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] peer_packets;
        logic [15:0] peer_packet_bytes;
        logic [15:0] peer_received_count;
        logic [31:0] peer_bandwidth;
        logic [15:0] peer_loss;
    } t_in;

    // Output request payload.
    typedef struct packed {
        logic [2:0]  send_kind;
        logic [15:0] packet_id;
        logic [15:0] message_bytes;
        logic [15:0] report_count;
        logic [15:0] report_expected;
        logic [31:0] report_bandwidth;
        logic [15:0] report_loss;
        logic [2:0]  mode;
        logic        timed_out;
        logic        last;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // load operands and start report arithmetic
        logic step;    // advance the arithmetic
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic        done;
        logic [31:0] bandwidth;
        logic [15:0] loss;
    } t_stat;
endpackage
`default_nettype wire

// ===== design/lbpe_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
`default_nettype none
interface lbpe_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/lbpe_datapath.sv =====
// Report arithmetic: shift-subtract divisions for loss and bandwidth.
`default_nettype none
module lbpe_datapath
    import lbpe_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic [COUNT_BITS-1:0] i_received,
    input  wire logic [15:0]           i_expected,
    input  wire logic [15:0]           i_size,
    input  wire logic [TIME_BITS-1:0]  i_span,
    output t_stat                      o_stat
);
    // Numerator kb*256000*r fits within 16+16+18+COUNT_BITS bits.
    localparam int NW = 50 + COUNT_BITS;
    localparam int DW = TIME_BITS + COUNT_BITS + 1;
    localparam int CW = $clog2(NW + 1);

    logic [2:0]      r_phase, n_phase;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [NW-1:0]   r_num, n_num;
    logic [DW-1:0]   r_den, n_den;
    logic [DW:0]     r_rem, n_rem;
    logic [NW-1:0]   r_quo, n_quo;
    logic [15:0]     r_lrem, n_lrem;
    logic [16:0]     r_lquo, n_lquo;
    logic [4:0]      r_lcnt, n_lcnt;
    logic [31:0]     r_kb, n_kb;
    logic [31:0]     r_bw, n_bw;
    logic [15:0]     r_loss, n_loss;
    logic            r_sat, n_sat;
    logic [DW:0]     w_trial;
    logic [16:0]     w_ltrial;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_KB   = 3'd1;
    localparam logic [2:0] PH_M1   = 3'd2;
    localparam logic [2:0] PH_M2   = 3'd3;
    localparam logic [2:0] PH_DIV  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    // Sequencing of the multiply and divide steps.
    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_num = r_num; n_den = r_den;
        n_rem = r_rem; n_quo = r_quo; n_lrem = r_lrem; n_lquo = r_lquo;
        n_lcnt = r_lcnt; n_kb = r_kb; n_bw = r_bw; n_loss = r_loss; n_sat = r_sat;
        w_trial = {r_rem[DW-1:0], r_num[NW-1]};
        w_ltrial = {r_lrem, 1'b0};
        if (i_cmd.start) begin
            n_phase = PH_KB;
            n_kb = 32'(({16'd0, i_received} * 32'(i_size)) >> 10);
            n_den = DW'(i_span) * DW'({1'b0, i_received} + 1'b1);
            n_sat = (i_span == '0);
            n_rem = '0; n_quo = '0; n_cnt = '0;
            n_lcnt = '0; n_lquo = '0; n_lrem = '0;
            if (i_expected != 16'd0 && 32'(i_received) < 32'(i_expected)) begin
                n_lrem = 16'(32'(i_expected) - 32'(i_received));
            end else begin
                n_lcnt = 5'd17;
            end
        end else if (i_cmd.step) begin
            // Loss: restoring division of diff*65536 by expected, one bit a step.
            if (r_lcnt < 5'd17) begin
                if (r_lcnt == 5'd0) begin
                    n_lrem = r_lrem;
                    n_lquo = '0;
                end else begin
                    if (w_ltrial >= {1'b0, i_expected}) begin
                        n_lrem = 16'(w_ltrial - {1'b0, i_expected});
                        n_lquo = {r_lquo[15:0], 1'b1};
                    end else begin
                        n_lrem = w_ltrial[15:0];
                        n_lquo = {r_lquo[15:0], 1'b0};
                    end
                end
                n_lcnt = r_lcnt + 5'd1;
            end
            unique case (r_phase)
                PH_KB: begin
                    n_num = NW'(r_kb) * NW'(18'd256000);
                    n_phase = PH_M1;
                end
                PH_M1: begin
                    n_num = NW'(r_num[47:0] * 64'(i_received));
                    n_phase = PH_M2;
                end
                PH_M2: n_phase = PH_DIV;
                PH_DIV: begin
                    if (w_trial >= {1'b0, r_den}) begin
                        n_rem = w_trial - {1'b0, r_den};
                        n_quo = {r_quo[NW-2:0], 1'b1};
                    end else begin
                        n_rem = w_trial;
                        n_quo = {r_quo[NW-2:0], 1'b0};
                    end
                    n_num = {r_num[NW-2:0], 1'b0};
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CW'(NW - 1)) n_phase = PH_DONE;
                end
                PH_DONE: begin
                    if (r_sat || r_quo[NW-1:32] != '0) n_bw = 32'hFFFF_FFFF;
                    else n_bw = r_quo[31:0];
                    n_loss = (r_lcnt == 5'd17 && r_lquo[16] == 1'b0) ? r_lquo[15:0] :
                             16'd0;
                    if (i_expected == 16'd0 || 32'(i_received) >= 32'(i_expected))
                        n_loss = 16'd0;
                    n_phase = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt <= '0;
            r_lcnt <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt <= n_cnt;
            r_lcnt <= n_lcnt;
        end
        r_num <= n_num; r_den <= n_den; r_rem <= n_rem; r_quo <= n_quo;
        r_lrem <= n_lrem; r_lquo <= n_lquo; r_kb <= n_kb; r_bw <= n_bw;
        r_loss <= n_loss; r_sat <= n_sat;
    end

    assign o_stat.done = (r_phase == PH_IDLE);
    assign o_stat.bandwidth = r_bw;
    assign o_stat.loss = r_loss;
endmodule
`default_nettype wire

// ===== design/lbpe_ctrl.sv =====
// Controller: protocol state, timers, counters and result sequencing.
`default_nettype none
module lbpe_ctrl
    import lbpe_pkg::*;
#(
    parameter int MAX_BURST  = 16,
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lbpe_stream_if.sink                in_if,
    lbpe_stream_if.source              out_if,
    input  wire logic [15:0]           i_cfg_packets,
    input  wire logic [15:0]           i_cfg_bytes,
    input  wire logic [23:0]           i_cfg_interval,
    input  wire logic [23:0]           i_cfg_timeout,
    input  wire logic [23:0]           i_cfg_idle,
    input  wire logic [23:0]           i_cfg_holdoff,
    output t_cmd                       o_cmd,
    input  wire t_stat                 i_stat,
    output logic [COUNT_BITS-1:0]      o_received,
    output logic [15:0]                o_expected,
    output logic [15:0]                o_size,
    output logic [TIME_BITS-1:0]       o_span
);
    localparam int BW = $clog2(MAX_BURST + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_BURST = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_LOAD  = 3'd6;

    logic [2:0]            r_state, n_state;
    t_in                   r_req, n_req;
    logic [2:0]            r_mode, n_mode;
    logic [TIME_BITS-1:0]  r_tick, n_tick, r_wait, n_wait, r_pace, n_pace;
    logic [TIME_BITS-1:0]  r_first, n_first, r_lastrx, n_lastrx, r_el, n_el;
    logic [COUNT_BITS-1:0] r_sent, n_sent, r_rcv, n_rcv;
    logic [15:0]           r_exp, n_exp, r_size, n_size;
    logic                  r_seen, n_seen, r_to, n_to;
    logic [31:0]           r_sbw, n_sbw;
    logic [15:0]           r_sloss, n_sloss, r_scnt, n_scnt, r_sexp, n_sexp;
    logic [BW-1:0]         r_n, n_n;
    logic                  r_ovalid, n_ovalid;
    t_out                  r_out, n_out;
    logic                  w_free;
    logic [TIME_BITS-1:0]  w_ival;
    logic [31:0]           w_rem, w_room;
    logic                  w_first, w_go, w_more, w_fin;

    assign w_free = !r_ovalid || out_if.ready;
    assign w_ival = TIME_BITS'(i_cfg_interval);
    assign in_if.ready = (r_state == S_IDLE);
    assign out_if.valid = r_ovalid;
    assign out_if.data = r_out;
    assign o_received = r_rcv;
    assign o_expected = r_exp;
    assign o_size = r_size;
    assign o_span = r_lastrx - r_first;

    // Builds one result from the given message and the current stored report.
    function automatic t_out mk(input logic [2:0] kind, input logic [15:0] id,
                                input logic [15:0] by, input logic [2:0] md,
                                input logic to, input logic lst,
                                input logic [15:0] sc, input logic [15:0] se,
                                input logic [31:0] sb, input logic [15:0] sl);
        t_out o;
        o.send_kind = kind; o.packet_id = id; o.message_bytes = by;
        o.report_count = sc; o.report_expected = se; o.report_bandwidth = sb;
        o.report_loss = sl; o.mode = md; o.timed_out = to; o.last = lst;
        return o;
    endfunction

    // Burst decisions: send now, another packet follows, and whether this tick
    // completes the count (then every packet of the tick shows wait report).
    always_comb begin
        w_rem = 32'(r_exp) - 32'(r_sent);
        w_room = 32'(MAX_BURST) - 32'(r_n);
        w_first = (i_cfg_interval != 24'd0) && (r_sent == '0) && (r_n == '0);
        if (i_cfg_interval == 24'd0) begin
            w_go = (w_room != 32'd0) && (w_rem != 32'd0);
            w_more = (w_room > 32'd1) && (w_rem > 32'd1);
            w_fin = (w_rem <= w_room);
        end else if (w_first) begin
            w_go = 1'b1;
            w_more = 1'b0;
            w_fin = (w_rem <= 32'd1);
        end else begin
            w_go = (w_room != 32'd0) && (w_rem != 32'd0) && (r_el >= w_ival);
            w_more = (w_room > 32'd1) && (w_rem > 32'd1) && (r_el - w_ival >= w_ival);
            w_fin = (w_rem <= w_room) &&
                    (64'(w_rem) * 64'(i_cfg_interval) <= 64'(r_el));
        end
    end

    always_comb begin
        n_state = r_state; n_req = r_req; n_mode = r_mode; n_tick = r_tick;
        n_wait = r_wait; n_pace = r_pace; n_first = r_first; n_lastrx = r_lastrx;
        n_el = r_el; n_sent = r_sent; n_rcv = r_rcv; n_exp = r_exp; n_size = r_size;
        n_seen = r_seen; n_to = r_to; n_sbw = r_sbw; n_sloss = r_sloss;
        n_scnt = r_scnt; n_sexp = r_sexp; n_n = r_n;
        n_ovalid = r_ovalid && !out_if.ready; n_out = r_out;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_if.valid) begin
                    n_req = in_if.data;
                    n_state = S_EXEC;
                end
            end
            // Applies the event; single result or hands over to burst/report.
            S_EXEC: begin
                if (w_free) begin
                    n_to = 1'b0;
                    n_state = S_FIN;
                    unique case (r_req.func)
                        FUNC_TICK: begin
                            n_tick = r_tick + 1'b1;
                            n_state = S_FIN;
                            if (r_mode == MODE_WACK || r_mode == MODE_WREP) begin
                                if (r_tick + 1'b1 - r_wait > TIME_BITS'(i_cfg_timeout)) begin
                                    n_mode = MODE_IDLE; n_to = 1'b1;
                                end
                            end else if (r_mode == MODE_SEND) begin
                                n_n = '0;
                                n_el = r_tick + 1'b1 - r_pace;
                                n_state = S_BURST;
                            end else if (r_mode == MODE_COUNT) begin
                                if (!r_seen) begin
                                    if (r_tick + 1'b1 - r_wait >
                                        TIME_BITS'(i_cfg_timeout)) begin
                                        n_mode = MODE_IDLE; n_to = 1'b1;
                                    end
                                end else if (r_tick + 1'b1 - r_lastrx >
                                             TIME_BITS'(i_cfg_idle)) begin
                                    if (r_tick + 1'b1 - r_lastrx <
                                        TIME_BITS'(i_cfg_holdoff)) begin
                                        n_mode = MODE_HOLD; n_wait = r_tick + 1'b1;
                                    end else begin
                                        n_state = S_LOAD;
                                    end
                                end
                            end else if (r_mode == MODE_HOLD) begin
                                if (r_tick + 1'b1 - r_wait >=
                                    TIME_BITS'(i_cfg_holdoff)) begin
                                    n_state = S_LOAD;
                                end
                            end
                        end
                        FUNC_START: begin
                            if (r_mode == MODE_IDLE || r_mode == MODE_DONE_TX ||
                                r_mode == MODE_DONE_RX) begin
                                n_exp = (i_cfg_packets != 16'd0) ? i_cfg_packets :
                                        DEFAULT_PACKETS;
                                n_size = (i_cfg_bytes != 16'd0) ? i_cfg_bytes :
                                         DEFAULT_BYTES;
                                n_sent = '0; n_rcv = '0; n_pace = '0; n_first = '0;
                                n_lastrx = '0; n_seen = 1'b0;
                                n_sbw = '0; n_sloss = '0; n_scnt = '0; n_sexp = '0;
                                n_wait = r_tick; n_mode = MODE_WACK;
                                n_ovalid = 1'b1;
                                n_out = mk(KIND_BEGIN, n_exp, n_size, MODE_WACK, 1'b0,
                                           1'b1, 16'd0, 16'd0, 32'd0, 16'd0);
                                n_state = S_IDLE;
                            end
                        end
                        FUNC_BEGIN: begin
                            if (r_mode == MODE_IDLE || r_mode == MODE_DONE_TX ||
                                r_mode == MODE_DONE_RX) begin
                                n_exp = r_req.peer_packets;
                                n_size = r_req.peer_packet_bytes;
                                n_rcv = '0; n_seen = 1'b0; n_first = '0; n_lastrx = '0;
                                n_sbw = '0; n_sloss = '0; n_scnt = '0;
                                n_sexp = r_req.peer_packets;
                                n_wait = r_tick; n_mode = MODE_COUNT;
                                n_ovalid = 1'b1;
                                n_out = mk(KIND_ACK, 16'd0, n_size, MODE_COUNT, 1'b0,
                                           1'b1, 16'd0, n_sexp, 32'd0, 16'd0);
                                n_state = S_IDLE;
                            end
                        end
                        FUNC_ACK: begin
                            if (r_mode == MODE_WACK) n_mode = MODE_SEND;
                        end
                        FUNC_DATA: begin
                            if (r_mode == MODE_COUNT) begin
                                if (r_rcv < CMAX) n_rcv = r_rcv + 1'b1;
                                if (!r_seen) begin
                                    n_first = r_tick; n_seen = 1'b1;
                                end
                                n_lastrx = r_tick;
                                if (32'(n_rcv) >= 32'(r_exp)) begin
                                    if (TIME_BITS'(0) < TIME_BITS'(i_cfg_holdoff)) begin
                                        n_mode = MODE_HOLD; n_wait = r_tick;
                                    end else begin
                                        n_state = S_LOAD;
                                    end
                                end
                            end
                        end
                        FUNC_REPORT: begin
                            if (r_mode == MODE_WREP) begin
                                n_scnt = r_req.peer_received_count;
                                n_sexp = r_req.peer_packets;
                                n_sbw = r_req.peer_bandwidth;
                                n_sloss = r_req.peer_loss;
                                n_mode = MODE_DONE_TX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Sends probe packets, one per cycle unless the output stalls, up to
            // the burst limit; the final packet of the tick carries last.
            S_BURST: begin
                if (w_free) begin
                    if (w_go) begin
                        n_ovalid = 1'b1;
                        n_out = mk(KIND_DATA, 16'(r_sent), r_size,
                                   w_fin ? MODE_WREP : r_mode, 1'b0, !w_more,
                                   r_scnt, r_sexp, r_sbw, r_sloss);
                        n_sent = r_sent + 1'b1; n_n = r_n + 1'b1;
                        if (w_first) begin
                            n_pace = r_tick;
                        end else if (i_cfg_interval != 24'd0) begin
                            n_pace = r_pace + w_ival; n_el = r_el - w_ival;
                        end
                        if (!w_more) begin
                            if (w_fin) begin
                                n_mode = MODE_WREP; n_wait = r_tick;
                            end
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            // Starts the report arithmetic once the counters have settled.
            S_LOAD: begin
                o_cmd.start = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.step = 1'b1;
                if (i_stat.done && !o_cmd.start) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_free) begin
                    n_sbw = i_stat.bandwidth; n_sloss = i_stat.loss;
                    n_scnt = 16'(r_rcv); n_sexp = r_exp;
                    n_mode = MODE_DONE_RX; n_seen = 1'b0;
                    n_first = '0; n_lastrx = '0;
                    n_ovalid = 1'b1;
                    n_out = mk(KIND_REPORT, 16'd0, r_size, MODE_DONE_RX, 1'b0, 1'b1,
                               16'(r_rcv), r_exp, i_stat.bandwidth, i_stat.loss);
                    n_state = S_IDLE;
                end
            end
            // Closing result for an event that sends nothing.
            S_FIN: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_out = mk(KIND_NONE, 16'd0, 16'd0, r_mode, r_to, 1'b1,
                               r_scnt, r_sexp, r_sbw, r_sloss);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_mode <= MODE_IDLE; r_tick <= '0; r_wait <= '0;
            r_pace <= '0; r_first <= '0; r_lastrx <= '0; r_sent <= '0; r_rcv <= '0;
            r_exp <= '0; r_size <= '0; r_seen <= 1'b0; r_to <= 1'b0; r_sbw <= '0;
            r_sloss <= '0; r_scnt <= '0; r_sexp <= '0; r_ovalid <= 1'b0;
            r_n <= '0;
        end else begin
            r_state <= n_state; r_mode <= n_mode; r_tick <= n_tick; r_wait <= n_wait;
            r_pace <= n_pace; r_first <= n_first; r_lastrx <= n_lastrx;
            r_sent <= n_sent; r_rcv <= n_rcv; r_exp <= n_exp; r_size <= n_size;
            r_seen <= n_seen; r_to <= n_to; r_sbw <= n_sbw; r_sloss <= n_sloss;
            r_scnt <= n_scnt; r_sexp <= n_sexp; r_ovalid <= n_ovalid;
            r_n <= n_n;
        end
        r_req <= n_req; r_el <= n_el; r_out <= n_out;
    end
endmodule
`default_nettype wire

// ===== design/link_bandwidth_probe_engine_core.sv =====
// Top level of the link bandwidth probe engine.
//  channel | direction | payload
//  in_if   | sink      | event request (func and peer message fields)
//  out_if  | source    | result request (message, stored report, mode)
//  apb     | slave     | six configuration registers at 4*i
// One event request is handled at a time.
// A tick in the sending phase emits its probe packets back to back.
// A report waits for the bit-serial bandwidth divider.
// Reset is synchronous and active low; output stalls hold the sequencer.
`default_nettype none
module link_bandwidth_probe_engine_core
    import lbpe_pkg::*;
#(
    parameter int MAX_BURST  = 16,
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lbpe_stream_if.sink      in_if,
    lbpe_stream_if.source    out_if,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [15:0] r_cfg_packets, r_cfg_bytes;
    logic [23:0] r_cfg_interval, r_cfg_timeout, r_cfg_idle, r_cfg_holdoff;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [COUNT_BITS-1:0] w_rcv;
    logic [15:0] w_exp, w_size;
    logic [TIME_BITS-1:0] w_span;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_packets <= 16'd200; r_cfg_bytes <= 16'd8192;
            r_cfg_interval <= '0; r_cfg_timeout <= 24'd10000;
            r_cfg_idle <= 24'd5000; r_cfg_holdoff <= 24'd1000;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_PACKETS:  r_cfg_packets <= pwdata[15:0];
                REG_BYTES:    r_cfg_bytes <= pwdata[15:0];
                REG_INTERVAL: r_cfg_interval <= pwdata[23:0];
                REG_TIMEOUT:  r_cfg_timeout <= pwdata[23:0];
                REG_IDLE:     r_cfg_idle <= pwdata[23:0];
                REG_HOLDOFF:  r_cfg_holdoff <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            REG_PACKETS:  prdata = {16'd0, r_cfg_packets};
            REG_BYTES:    prdata = {16'd0, r_cfg_bytes};
            REG_INTERVAL: prdata = {8'd0, r_cfg_interval};
            REG_TIMEOUT:  prdata = {8'd0, r_cfg_timeout};
            REG_IDLE:     prdata = {8'd0, r_cfg_idle};
            REG_HOLDOFF:  prdata = {8'd0, r_cfg_holdoff};
            default:      prdata = 32'd0;
        endcase
    end

    lbpe_ctrl #(.MAX_BURST(MAX_BURST), .COUNT_BITS(COUNT_BITS), .TIME_BITS(TIME_BITS))
    u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_if(in_if), .out_if(out_if),
        .i_cfg_packets(r_cfg_packets), .i_cfg_bytes(r_cfg_bytes),
        .i_cfg_interval(r_cfg_interval), .i_cfg_timeout(r_cfg_timeout),
        .i_cfg_idle(r_cfg_idle), .i_cfg_holdoff(r_cfg_holdoff),
        .o_cmd(w_cmd), .i_stat(w_stat), .o_received(w_rcv), .o_expected(w_exp),
        .o_size(w_size), .o_span(w_span)
    );

    lbpe_datapath #(.COUNT_BITS(COUNT_BITS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_received(w_rcv),
        .i_expected(w_exp), .i_size(w_size), .i_span(w_span), .o_stat(w_stat)
    );
endmodule
`default_nettype wire

// ===== design/lbpe_checker.sv =====
// Port-level checker for the probe engine, bound to the top level.
`default_nettype none
module lbpe_checker
    import lbpe_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire t_out out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output request dropped or changed under stall");
    a_timeout_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.timed_out |-> out_data.mode == MODE_IDLE)
        else $error("timeout without idle mode");
    a_report_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.send_kind == KIND_REPORT |-> out_data.mode == MODE_DONE_RX)
        else $error("report sent outside done receiver");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");
endmodule

bind link_bandwidth_probe_engine_core lbpe_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire

// ===== sim/link_bandwidth_probe_engine_core_tb.sv =====
// Self-checking testbench for the link bandwidth probe engine core.
`default_nettype none
module link_bandwidth_probe_engine_core_tb;
    import lbpe_pkg::*;

    localparam int          PROBE_BURST  = 16;
    localparam logic [2:0]  FUNC_SPARE_A = 3'd6;
    localparam logic [2:0]  FUNC_SPARE_B = 3'd7;
    localparam int          NUM_PHASES   = 6;
    localparam int          PHASE_ITEMS  = 50;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_START   = 2000;
    localparam int          HOLD_CYCLES  = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lbpe_stream_if #(.T(t_in))  in_if ();
    lbpe_stream_if #(.T(t_out)) out_if ();

    link_bandwidth_probe_engine_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_if   (in_if.sink),
        .out_if  (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Event requests waiting to be driven and results waiting to arrive.
    t_in  event_queue[$];
    t_out result_queue[$];
    int   error_count = 0;
    int   cycle_count = 0;

    // Predictor state, kept at the widths of the block.
    logic [31:0] cfg_val [6];
    logic [2:0]  p_mode;
    logic [31:0] p_tick, p_wait_start, p_pace_mark, p_first_rx, p_last_rx;
    logic [15:0] p_sent, p_received, p_expected, p_peer_size;
    logic        p_data_seen;
    logic [31:0] p_bandwidth;
    logic [15:0] p_loss, p_count, p_rep_expected;

    // Messages produced by the event being predicted.
    logic [2:0]  msg_kind[$];
    logic [15:0] msg_id[$];
    logic [15:0] msg_bytes[$];

    function automatic logic [31:0] elapsed(logic [31:0] now, logic [31:0] then_t);
        return now - then_t;
    endfunction

    function automatic bit probe_busy();
        return p_mode != MODE_IDLE && p_mode != MODE_DONE_TX && p_mode != MODE_DONE_RX;
    endfunction

    task automatic add_message(logic [2:0] kind, logic [15:0] id, logic [15:0] bytes);
        msg_kind.push_back(kind);
        msg_id.push_back(id);
        msg_bytes.push_back(bytes);
    endtask

    // Loss and bandwidth of the receiver, then the report message.
    task automatic issue_report();
        longint unsigned r, e, loss, span, kb, num, den, bw;
        r = p_received;
        e = p_expected;
        loss = 0;
        if (e != 0 && r < e) begin
            loss = ((e - r) * 65536) / e;
        end
        span = elapsed(p_last_rx, p_first_rx);
        kb = (r * p_peer_size) / 1024;
        den = span * (r + 1);
        if (span == 0 || den == 0) begin
            bw = 64'hFFFF_FFFF;
        end else begin
            num = kb * 256000 * r;
            bw = num / den;
            if (bw > 64'hFFFF_FFFF) begin
                bw = 64'hFFFF_FFFF;
            end
        end
        p_bandwidth = bw[31:0];
        p_loss = loss[15:0];
        p_count = p_received;
        p_rep_expected = p_expected;
        add_message(KIND_REPORT, 16'd0, p_peer_size);
        p_mode = MODE_DONE_RX;
        p_data_seen = 1'b0;
        p_first_rx = '0;
        p_last_rx = '0;
    endtask

    task automatic ask_report();
        if (elapsed(p_tick, p_last_rx) < cfg_val[REG_HOLDOFF]) begin
            p_mode = MODE_HOLD;
            p_wait_start = p_tick;
        end else begin
            issue_report();
        end
    endtask

    task automatic send_probe();
        add_message(KIND_DATA, p_sent, p_peer_size);
        p_sent = p_sent + 16'd1;
    endtask

    // Burst or paced sending on a tick.
    task automatic sender_tick();
        logic [31:0] ival, el;
        int n;
        ival = cfg_val[REG_INTERVAL];
        n = 0;
        if (ival == 0) begin
            while (n < PROBE_BURST && p_sent < p_expected) begin
                send_probe();
                n++;
            end
        end else if (p_sent == 0) begin
            send_probe();
            p_pace_mark = p_tick;
        end else begin
            el = elapsed(p_tick, p_pace_mark);
            while (n < PROBE_BURST && p_sent < p_expected && el >= ival) begin
                send_probe();
                p_pace_mark = p_pace_mark + ival;
                el = el - ival;
                n++;
            end
        end
        if (p_sent >= p_expected) begin
            p_sent = p_expected;
            p_mode = MODE_WREP;
            p_wait_start = p_tick;
        end
    endtask

    // Advance the predictor by one event and queue the expected results.
    task automatic predict_event(t_in ev);
        bit   tmo;
        t_out res;
        tmo = 1'b0;
        msg_kind.delete();
        msg_id.delete();
        msg_bytes.delete();
        case (ev.func)
            FUNC_TICK: begin
                p_tick = p_tick + 32'd1;
                if (p_mode == MODE_WACK || p_mode == MODE_WREP) begin
                    if (elapsed(p_tick, p_wait_start) > cfg_val[REG_TIMEOUT]) begin
                        p_mode = MODE_IDLE;
                        tmo = 1'b1;
                    end
                end else if (p_mode == MODE_SEND) begin
                    sender_tick();
                end else if (p_mode == MODE_COUNT) begin
                    if (!p_data_seen) begin
                        if (elapsed(p_tick, p_wait_start) > cfg_val[REG_TIMEOUT]) begin
                            p_mode = MODE_IDLE;
                            tmo = 1'b1;
                        end
                    end else if (elapsed(p_tick, p_last_rx) > cfg_val[REG_IDLE]) begin
                        ask_report();
                    end
                end else if (p_mode == MODE_HOLD) begin
                    if (elapsed(p_tick, p_wait_start) >= cfg_val[REG_HOLDOFF]) begin
                        issue_report();
                    end
                end
            end
            FUNC_START: begin
                if (!probe_busy()) begin
                    p_expected = (cfg_val[REG_PACKETS][15:0] != 0) ?
                                 cfg_val[REG_PACKETS][15:0] : DEFAULT_PACKETS;
                    p_peer_size = (cfg_val[REG_BYTES][15:0] != 0) ?
                                  cfg_val[REG_BYTES][15:0] : DEFAULT_BYTES;
                    p_sent = '0;
                    p_received = '0;
                    p_pace_mark = '0;
                    p_first_rx = '0;
                    p_last_rx = '0;
                    p_data_seen = 1'b0;
                    p_bandwidth = '0;
                    p_loss = '0;
                    p_count = '0;
                    p_rep_expected = '0;
                    add_message(KIND_BEGIN, p_expected, p_peer_size);
                    p_wait_start = p_tick;
                    p_mode = MODE_WACK;
                end
            end
            FUNC_BEGIN: begin
                if (!probe_busy()) begin
                    p_expected = ev.peer_packets;
                    p_peer_size = ev.peer_packet_bytes;
                    p_received = '0;
                    p_data_seen = 1'b0;
                    p_first_rx = '0;
                    p_last_rx = '0;
                    p_bandwidth = '0;
                    p_loss = '0;
                    p_count = '0;
                    p_rep_expected = p_expected;
                    add_message(KIND_ACK, 16'd0, p_peer_size);
                    p_wait_start = p_tick;
                    p_mode = MODE_COUNT;
                end
            end
            FUNC_ACK: begin
                if (p_mode == MODE_WACK) begin
                    p_mode = MODE_SEND;
                end
            end
            FUNC_DATA: begin
                if (p_mode == MODE_COUNT) begin
                    if (p_received != 16'hFFFF) begin
                        p_received = p_received + 16'd1;
                    end
                    if (!p_data_seen) begin
                        p_first_rx = p_tick;
                        p_data_seen = 1'b1;
                    end
                    p_last_rx = p_tick;
                    if (p_received >= p_expected) begin
                        ask_report();
                    end
                end
            end
            FUNC_REPORT: begin
                if (p_mode == MODE_WREP) begin
                    p_count = ev.peer_received_count;
                    p_rep_expected = ev.peer_packets;
                    p_bandwidth = ev.peer_bandwidth;
                    p_loss = ev.peer_loss;
                    p_mode = MODE_DONE_TX;
                end
            end
            default: begin
            end
        endcase
        if (msg_kind.size() == 0) begin
            add_message(KIND_NONE, 16'd0, 16'd0);
        end
        foreach (msg_kind[k]) begin
            res.send_kind = msg_kind[k];
            res.packet_id = msg_id[k];
            res.message_bytes = msg_bytes[k];
            res.report_count = p_count;
            res.report_expected = p_rep_expected;
            res.report_bandwidth = p_bandwidth;
            res.report_loss = p_loss;
            res.mode = p_mode;
            res.timed_out = tmo;
            res.last = (k == msg_kind.size() - 1);
            result_queue.push_back(res);
        end
    endtask

    // Build one event with random peer fields, predict it and queue it.
    int phase_items;

    task automatic post_event(logic [2:0] func, logic [15:0] packets);
        t_in ev;
        ev.func = func;
        ev.peer_packets = 16'($urandom());
        ev.peer_packet_bytes = 16'($urandom());
        ev.peer_received_count = 16'($urandom());
        ev.peer_bandwidth = $urandom();
        ev.peer_loss = 16'($urandom());
        if (func == FUNC_BEGIN) begin
            ev.peer_packets = packets;
        end
        predict_event(ev);
        event_queue.push_back(ev);
        phase_items++;
    endtask

    task automatic post_noise();
        logic [2:0] pick;
        pick = 3'($urandom_range(0, 5));
        case (pick)
            0: post_event(FUNC_TICK, '0);
            1: post_event(FUNC_ACK, '0);
            2: post_event(FUNC_DATA, '0);
            3: post_event(FUNC_REPORT, '0);
            4: post_event(FUNC_SPARE_A, '0);
            default: post_event(FUNC_SPARE_B, '0);
        endcase
    endtask

    task automatic ticks_while_busy(int cap);
        int n;
        n = 0;
        while (probe_busy() && n < cap) begin
            post_event(FUNC_TICK, '0);
            n++;
        end
    endtask

    // One sender probe: start, then a time-out before the ack, or ack, send, and report or time out.
    task automatic sender_run(bit force_timeout);
        int n;
        post_event(FUNC_START, '0);
        repeat ($urandom_range(0, 3)) post_event(FUNC_TICK, '0);
        if (force_timeout || $urandom_range(0, 9) == 0) begin
            ticks_while_busy(60);
        end else begin
            post_event(FUNC_ACK, '0);
            n = 0;
            while (p_mode == MODE_SEND && n < 40) begin
                post_event(FUNC_TICK, '0);
                n++;
            end
            if (p_mode == MODE_WREP) begin
                if ($urandom_range(0, 9) < 8) begin
                    repeat ($urandom_range(0, 2)) post_event(FUNC_TICK, '0);
                    post_event(FUNC_REPORT, '0);
                end else begin
                    ticks_while_busy(60);
                end
            end
        end
    endtask

    // One receiver probe: begin, data mixed with ticks, then the report or a time-out.
    task automatic receiver_run(bit allow_big);
        logic [15:0] pkts;
        int n;
        pkts = 16'($urandom_range(0, 12));
        if (allow_big && $urandom_range(0, 19) == 0) begin
            pkts = 16'($urandom());
        end
        post_event(FUNC_BEGIN, pkts);
        n = 0;
        while (p_mode == MODE_COUNT && n < 30) begin
            if ($urandom_range(0, 9) < 7) begin
                post_event(FUNC_DATA, '0);
            end else begin
                post_event(FUNC_TICK, '0);
            end
            n++;
        end
        ticks_while_busy(60);
    endtask

    // Bring the predicted state back to a finished probe.
    task automatic settle_probe();
        int n;
        n = 0;
        while (probe_busy() && n < 3000) begin
            if (p_mode == MODE_WREP) begin
                post_event(FUNC_REPORT, '0);
            end else if (p_mode == MODE_WACK && cfg_val[REG_TIMEOUT] > 1000) begin
                post_event(FUNC_ACK, '0);
            end else if (p_mode == MODE_COUNT && p_data_seen) begin
                post_event(FUNC_DATA, '0);
            end else begin
                post_event(FUNC_TICK, '0);
            end
            n++;
        end
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_val[idx] = value & ((idx < REG_INTERVAL) ? 32'h0000_FFFF : 32'h00FF_FFFF);
    endtask

    task automatic wait_drained();
        while (event_queue.size() != 0 || in_if.valid || result_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    // Driver: offers queued event requests, idling now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data <= '0;
        end else if (!in_if.valid || in_if.ready) begin
            if (event_queue.size() != 0 &&
                ((cycle_count > 6000 && cycle_count < 9000) || $urandom_range(0, 99) >= 8)) begin
                in_if.data <= event_queue.pop_front();
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver side: random stalls, one long hold-off, and a quiet stretch.
    int hold_left = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (cycle_count == HOLD_START) begin
            hold_left <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= (hold_left == 1);
        end else begin
            out_if.ready <= (cycle_count > 6000 && cycle_count < 9000) ||
                            ($urandom_range(0, 99) >= 8);
        end
    end

    // Monitor: compare each result request with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (result_queue.size() == 0) begin
                $error("unexpected result request: %p", got);
                error_count++;
            end else begin
                want = result_queue.pop_front();
                if (got.send_kind !== want.send_kind) begin
                    $error("send_kind: expected %0d, actual %0d", want.send_kind, got.send_kind);
                    error_count++;
                end
                if (got.packet_id !== want.packet_id) begin
                    $error("packet_id: expected %0d, actual %0d", want.packet_id, got.packet_id);
                    error_count++;
                end
                if (got.message_bytes !== want.message_bytes) begin
                    $error("message_bytes: expected %0d, actual %0d",
                           want.message_bytes, got.message_bytes);
                    error_count++;
                end
                if (got.report_count !== want.report_count) begin
                    $error("report_count: expected %0d, actual %0d",
                           want.report_count, got.report_count);
                    error_count++;
                end
                if (got.report_expected !== want.report_expected) begin
                    $error("report_expected: expected %0d, actual %0d",
                           want.report_expected, got.report_expected);
                    error_count++;
                end
                if (got.report_bandwidth !== want.report_bandwidth) begin
                    $error("report_bandwidth: expected %h, actual %h",
                           want.report_bandwidth, got.report_bandwidth);
                    error_count++;
                end
                if (got.report_loss !== want.report_loss) begin
                    $error("report_loss: expected %h, actual %h", want.report_loss, got.report_loss);
                    error_count++;
                end
                if (got.mode !== want.mode) begin
                    $error("mode: expected %0d, actual %0d", want.mode, got.mode);
                    error_count++;
                end
                if (got.timed_out !== want.timed_out) begin
                    $error("timed_out: expected %0d, actual %0d", want.timed_out, got.timed_out);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Run guard.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Register settings per phase: packets, bytes, interval, timeout, idle, holdoff.
    logic [31:0] phase_cfg [NUM_PHASES][6] = '{
        '{32'd0,     32'd0,     32'd0,        32'd8,        32'd4,        32'd2},
        '{32'd5,     32'd16,    32'd2,        32'd6,        32'd3,        32'd0},
        '{32'd65535, 32'd65535, 32'd1,        32'd5,        32'h00FF_FFFF, 32'd0},
        '{32'd1,     32'd100,   32'h00FF_FFFF, 32'h00FF_FFFF, 32'd2,       32'h00FF_FFFF},
        '{32'd1,     32'd16,    32'd0,        32'd1,        32'd1,        32'd0},
        '{32'd7,     32'd1000,  32'd1,        32'd20,       32'd5,        32'd3}
    };

    initial begin
        int pick;
        cfg_val = '{32'd200, 32'd8192, 32'd0, 32'd10000, 32'd5000, 32'd1000};
        p_mode = MODE_IDLE;
        p_tick = '0;
        p_wait_start = '0;
        p_pace_mark = '0;
        p_first_rx = '0;
        p_last_rx = '0;
        p_sent = '0;
        p_received = '0;
        p_expected = '0;
        p_peer_size = '0;
        p_data_seen = 1'b0;
        p_bandwidth = '0;
        p_loss = '0;
        p_count = '0;
        p_rep_expected = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Directed: ignored events, spare codes, and a default-sized sender probe.
        phase_items = 0;
        post_event(FUNC_SPARE_A, '0);
        post_event(FUNC_SPARE_B, '0);
        post_event(FUNC_ACK, '0);
        post_event(FUNC_DATA, '0);
        post_event(FUNC_REPORT, '0);
        post_event(FUNC_TICK, '0);
        sender_run(1'b0);
        settle_probe();
        // A receiver probe that expects nothing reports on its first data.
        wait_drained();
        apb_write(REG_HOLDOFF, 32'd0);
        post_event(FUNC_BEGIN, 16'd0);
        post_event(FUNC_DATA, '0);
        settle_probe();
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int r = 0; r < 6; r++) begin
                apb_write(r[2:0], phase_cfg[ph][r]);
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 4 && ph != 3) begin
                    receiver_run(ph == 0 || ph == 1 || ph == 5);
                end else if (pick < 8) begin
                    sender_run(ph == 2);
                end else begin
                    repeat ($urandom_range(1, 4)) post_noise();
                end
                settle_probe();
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (error_count == 0 && result_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== link_bandwidth_probe_engine_core.f =====
design/lbpe_pkg.sv
design/lbpe_stream_if.sv
design/lbpe_datapath.sv
design/lbpe_ctrl.sv
design/link_bandwidth_probe_engine_core.sv
design/lbpe_checker.sv
sim/link_bandwidth_probe_engine_core_tb.sv
